// ===== sv/vdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constants for the vertex displacement pipeline.
// No dependencies; every other file refers to it by scoped names.
package vdd_pkg;

   // Direction codes in mode bits 2:0
   localparam logic [2:0] DIR_X      = 3'd0;
   localparam logic [2:0] DIR_Y      = 3'd1;
   localparam logic [2:0] DIR_Z      = 3'd2;
   localparam logic [2:0] DIR_RGB    = 3'd3;
   localparam logic [2:0] DIR_NORMAL = 3'd4;
   localparam logic [2:0] DIR_CUSTOM = 3'd5;

   // Register indexes on the csr port
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_STRENGTH = 3'd1;
   localparam logic [2:0] REG_MIDLEVEL = 3'd2;
   localparam logic [2:0] REG_ROW0     = 3'd3;
   localparam logic [2:0] REG_ROW1     = 3'd4;
   localparam logic [2:0] REG_ROW2     = 3'd5;

   // Register defaults: direction normal, strength 1.0, midlevel 0.5, identity matrix
   localparam logic [5:0]  ModeReset     = 6'd4;
   localparam logic [31:0] StrengthReset = 32'd65536;
   localparam logic [31:0] MidlevelReset = 32'd32768;
   localparam logic [47:0] Row0Reset     = 48'd16384;
   localparam logic [47:0] Row1Reset     = 48'd1073741824;
   localparam logic [47:0] Row2Reset     = 48'd70368744177664;

   // Magnitude caps of the strength product, Q32.32
   localparam logic [50:0] DeltaCap = 51'd42949672960000;
   localparam logic [50:0] RgbCap   = 51'h4_0000_0000_0000;

   localparam int unsigned ReqDataW = 232;
   localparam int unsigned RspDataW = 96;
   localparam int unsigned CsrDataW = 48;

   typedef struct packed {
      logic [2:0]             dir;
      logic                   glob;
      logic                   tex;
      logic                   wen;
      logic [31:0]            strength;
      logic [31:0]            midlevel;
      logic [2:0][2:0][15:0]  mat;       // [row][col], signed Q2.14
   } cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [16:0]      tex_intensity;
      logic [2:0][16:0] rgb;
      logic [16:0]      weight;
      logic [2:0][15:0] nrm;
   } vertex_type;

   // prep -> scale: operand magnitudes and signs per lane
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] nrm;
      logic [2:0][33:0] amag;
      logic [2:0]       aneg;
      logic [31:0]      smag;
      logic             bypass;
   } scale_in_type;

   // scale -> dir: rounded displacement magnitudes per lane
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] nrm;
      logic [2:0][34:0] dm;
      logic [2:0]       dneg;
      logic             bypass;
   } scale_out_type;

endpackage

// ===== sv/vdd_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file: mode, strength, midlevel and the 3x3 matrix.
// Depends on vdd_pkg for register codes, defaults and cfg_type.
module vdd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [2:0]                    csr_index,
   input  logic [vdd_pkg::CsrDataW-1:0]  csr_wdata,
   output vdd_pkg::cfg_type              cfg
);

   logic [5:0]       mode_ff, mode_in;
   logic [31:0]      strength_ff, strength_in;
   logic [31:0]      midlevel_ff, midlevel_in;
   logic [2:0][47:0] row_ff, row_in;

   // decode writes
   always_comb begin
      mode_in     = mode_ff;
      strength_in = strength_ff;
      midlevel_in = midlevel_ff;
      row_in      = row_ff;
      if (csr_wen) begin
         unique case (csr_index)
            vdd_pkg::REG_MODE:     mode_in     = csr_wdata[5:0];
            vdd_pkg::REG_STRENGTH: strength_in = csr_wdata[31:0];
            vdd_pkg::REG_MIDLEVEL: midlevel_in = csr_wdata[31:0];
            vdd_pkg::REG_ROW0:     row_in[0]   = csr_wdata;
            vdd_pkg::REG_ROW1:     row_in[1]   = csr_wdata;
            vdd_pkg::REG_ROW2:     row_in[2]   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= vdd_pkg::ModeReset;
         strength_ff <= vdd_pkg::StrengthReset;
         midlevel_ff <= vdd_pkg::MidlevelReset;
         row_ff[0]   <= vdd_pkg::Row0Reset;
         row_ff[1]   <= vdd_pkg::Row1Reset;
         row_ff[2]   <= vdd_pkg::Row2Reset;
      end else begin
         mode_ff     <= mode_in;
         strength_ff <= strength_in;
         midlevel_ff <= midlevel_in;
         row_ff      <= row_in;
      end
   end

   // split mode bits and matrix entries
   always_comb begin
      cfg.dir      = mode_ff[2:0];
      cfg.glob     = mode_ff[3];
      cfg.tex      = mode_ff[4];
      cfg.wen      = mode_ff[5];
      cfg.strength = strength_ff;
      cfg.midlevel = midlevel_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cfg.mat[r][c] = row_ff[r][16*c +: 16];
         end
      end
   end

endmodule

// ===== sv/vdd_prep.sv =====
`timescale 1ns / 1ps
// Front four stages: effective strength, texture differences, matrix products,
// operand magnitudes. Depends on vdd_pkg.
module vdd_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  vdd_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  vdd_pkg::vertex_type    in_vtx,
   output logic                   out_valid,
   input  logic                   out_ready,
   output vdd_pkg::scale_in_type  out_word
);

   localparam int unsigned Stages = 4;

   logic [Stages-1:0] vld_ff, vld_in, adv, shift_vld;

   // stage 1
   logic [2:0][31:0] pos1_ff, pos1_in;
   logic [2:0][15:0] nrm1_ff, nrm1_in;
   logic [48:0]      sw1_ff, sw1_in;
   logic [31:0]      smag1_ff, smag1_in;
   logic             sneg1_ff, sneg1_in;
   logic [2:0][33:0] v1_ff, v1_in;
   logic [33:0]      t1_ff, t1_in;
   logic             bypass1_ff, bypass1_in;
   // stage 2
   logic [2:0][31:0]      pos2_ff, pos2_in;
   logic [2:0][15:0]      nrm2_ff, nrm2_in;
   logic [31:0]           smag2_ff, smag2_in;
   logic                  sneg2_ff, sneg2_in;
   logic [2:0][2:0][49:0] mp2_ff, mp2_in;
   logic [2:0][33:0]      v2_ff, v2_in;
   logic [33:0]           t2_ff, t2_in;
   logic                  bypass2_ff, bypass2_in;
   // stage 3
   logic [2:0][31:0] pos3_ff, pos3_in;
   logic [2:0][15:0] nrm3_ff, nrm3_in;
   logic [31:0]      smag3_ff, smag3_in;
   logic             sneg3_ff, sneg3_in;
   logic [2:0][51:0] acc3_ff, acc3_in;
   logic [2:0][33:0] v3_ff, v3_in;
   logic [33:0]      t3_ff, t3_in;
   logic             bypass3_ff, bypass3_in;
   // stage 4
   vdd_pkg::scale_in_type word4_ff, word4_in;

   logic [33:0] mid_ext;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      shift_vld = {vld_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         vld_in[k] = adv[k] ? shift_vld[k] : vld_ff[k];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_word  = word4_ff;
   assign mid_ext   = {{2{cfg.midlevel[31]}}, cfg.midlevel};

   // stage 1: strength magnitude times weight, differences from midlevel
   always_comb begin
      pos1_in  = in_vtx.pos;
      nrm1_in  = in_vtx.nrm;
      sneg1_in = cfg.strength[31];
      smag1_in = cfg.strength[31] ? (~cfg.strength + 32'd1) : cfg.strength;
      sw1_in   = 49'(smag1_in) * 49'(in_vtx.weight);
      for (int j = 0; j < 3; j++) begin
         v1_in[j] = {17'd0, in_vtx.rgb[j]} - mid_ext;
      end
      t1_in = (cfg.tex ? {17'd0, in_vtx.tex_intensity} : 34'd65536) - mid_ext;
      bypass1_in = (cfg.wen && (in_vtx.weight == 17'd0))
                || ((cfg.dir == vdd_pkg::DIR_RGB) && !cfg.tex)
                || (cfg.dir > vdd_pkg::DIR_CUSTOM);
   end

   // stage 2: round weighted strength, matrix products
   always_comb begin
      pos2_in    = pos1_ff;
      nrm2_in    = nrm1_ff;
      sneg2_in   = sneg1_ff;
      v2_in      = v1_ff;
      t2_in      = t1_ff;
      bypass2_in = bypass1_ff;
      smag2_in   = cfg.wen ? 32'((sw1_ff + 49'd32768) >> 16) : smag1_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mp2_in[i][j] = 50'($signed(cfg.mat[i][j])) * 50'($signed(v1_ff[j]));
         end
      end
   end

   // stage 3: row sums
   always_comb begin
      pos3_in    = pos2_ff;
      nrm3_in    = nrm2_ff;
      smag3_in   = smag2_ff;
      sneg3_in   = sneg2_ff;
      v3_in      = v2_ff;
      t3_in      = t2_ff;
      bypass3_in = bypass2_ff;
      for (int i = 0; i < 3; i++) begin
         acc3_in[i] = 52'($signed(mp2_ff[i][0])) + 52'($signed(mp2_ff[i][1]))
                    + 52'($signed(mp2_ff[i][2]));
      end
   end

   // stage 4: pick the lane operand and split it into sign and magnitude
   always_comb begin
      logic [51:0] abs_acc;
      logic [33:0] op;
      logic        neg;
      word4_in.pos    = pos3_ff;
      word4_in.nrm    = nrm3_ff;
      word4_in.smag   = smag3_ff;
      word4_in.bypass = bypass3_ff;
      for (int i = 0; i < 3; i++) begin
         abs_acc = acc3_ff[i][51] ? (~acc3_ff[i] + 52'd1) : acc3_ff[i];
         op      = (cfg.dir == vdd_pkg::DIR_RGB) ? v3_ff[i] : t3_ff;
         if (cfg.dir == vdd_pkg::DIR_RGB && cfg.glob) begin
            neg              = acc3_ff[i][51];
            word4_in.amag[i] = 34'((abs_acc + 52'd8192) >> 14);
         end else begin
            neg              = op[33];
            word4_in.amag[i] = neg ? (~op + 34'd1) : op;
         end
         word4_in.aneg[i] = neg ^ sneg3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pos1_ff    <= pos1_in;
         nrm1_ff    <= nrm1_in;
         sw1_ff     <= sw1_in;
         smag1_ff   <= smag1_in;
         sneg1_ff   <= sneg1_in;
         v1_ff      <= v1_in;
         t1_ff      <= t1_in;
         bypass1_ff <= bypass1_in;
      end
      if (adv[1]) begin
         pos2_ff    <= pos2_in;
         nrm2_ff    <= nrm2_in;
         smag2_ff   <= smag2_in;
         sneg2_ff   <= sneg2_in;
         mp2_ff     <= mp2_in;
         v2_ff      <= v2_in;
         t2_ff      <= t2_in;
         bypass2_ff <= bypass2_in;
      end
      if (adv[2]) begin
         pos3_ff    <= pos3_in;
         nrm3_ff    <= nrm3_in;
         smag3_ff   <= smag3_in;
         sneg3_ff   <= sneg3_in;
         acc3_ff    <= acc3_in;
         v3_ff      <= v3_in;
         t3_ff      <= t3_in;
         bypass3_ff <= bypass3_in;
      end
      if (adv[3]) begin
         word4_ff <= word4_in;
      end
   end

endmodule

// ===== sv/vdd_scale.sv =====
`timescale 1ns / 1ps
// Middle three stages: operand times strength as two partial products,
// magnitude clamp, rounding to Q16.16. Depends on vdd_pkg.
module vdd_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  vdd_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vdd_pkg::scale_in_type   in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vdd_pkg::scale_out_type  out_word
);

   localparam int unsigned Stages = 3;

   logic [Stages-1:0] vld_ff, vld_in, adv, shift_vld;

   // stage 1
   logic [2:0][31:0] pos5_ff, pos5_in;
   logic [2:0][15:0] nrm5_ff, nrm5_in;
   logic [2:0][48:0] pl5_ff, pl5_in, ph5_ff, ph5_in;
   logic [2:0]       neg5_ff, neg5_in;
   logic             bypass5_ff, bypass5_in;
   // stage 2
   logic [2:0][31:0] pos6_ff, pos6_in;
   logic [2:0][15:0] nrm6_ff, nrm6_in;
   logic [2:0][50:0] m6_ff, m6_in;
   logic [2:0]       neg6_ff, neg6_in;
   logic             bypass6_ff, bypass6_in;
   // stage 3
   vdd_pkg::scale_out_type word7_ff, word7_in;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      shift_vld = {vld_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         vld_in[k] = adv[k] ? shift_vld[k] : vld_ff[k];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_word  = word7_ff;

   // stage 1: low and high halves of the operand times strength
   always_comb begin
      pos5_in    = in_word.pos;
      nrm5_in    = in_word.nrm;
      neg5_in    = in_word.aneg;
      bypass5_in = in_word.bypass;
      for (int i = 0; i < 3; i++) begin
         pl5_in[i] = 49'(in_word.amag[i][16:0]) * 49'(in_word.smag);
         ph5_in[i] = 49'(in_word.amag[i][33:17]) * 49'(in_word.smag);
      end
   end

   // stage 2: combine halves, clamp to the mode's cap
   always_comb begin
      logic [65:0] prod;
      logic [50:0] cap;
      pos6_in    = pos5_ff;
      nrm6_in    = nrm5_ff;
      neg6_in    = neg5_ff;
      bypass6_in = bypass5_ff;
      cap = (cfg.dir == vdd_pkg::DIR_RGB) ? vdd_pkg::RgbCap : vdd_pkg::DeltaCap;
      for (int i = 0; i < 3; i++) begin
         prod     = {ph5_ff[i], 17'd0} + {17'd0, pl5_ff[i]};
         m6_in[i] = (prod > 66'(cap)) ? cap : prod[50:0];
      end
   end

   // stage 3: round Q32.32 to Q16.16
   always_comb begin
      word7_in.pos    = pos6_ff;
      word7_in.nrm    = nrm6_ff;
      word7_in.dneg   = neg6_ff;
      word7_in.bypass = bypass6_ff;
      for (int i = 0; i < 3; i++) begin
         word7_in.dm[i] = 35'((m6_ff[i] + 51'd32768) >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pos5_ff    <= pos5_in;
         nrm5_ff    <= nrm5_in;
         pl5_ff     <= pl5_in;
         ph5_ff     <= ph5_in;
         neg5_ff    <= neg5_in;
         bypass5_ff <= bypass5_in;
      end
      if (adv[1]) begin
         pos6_ff    <= pos6_in;
         nrm6_ff    <= nrm6_in;
         m6_ff      <= m6_in;
         neg6_ff    <= neg6_in;
         bypass6_ff <= bypass6_in;
      end
      if (adv[2]) begin
         word7_ff <= word7_in;
      end
   end

endmodule

// ===== sv/vdd_dir.sv =====
`timescale 1ns / 1ps
// Back five stages: direction product, divide by 32767, displacement select,
// saturating add to the position. Depends on vdd_pkg.
module vdd_dir (
   input  logic                    clock,
   input  logic                    reset,
   input  vdd_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vdd_pkg::scale_out_type  in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2:0][31:0]        out_pos
);

   localparam int unsigned Stages = 5;

   logic [Stages-1:0] vld_ff, vld_in, adv, shift_vld;

   // stage 1
   vdd_pkg::scale_out_type w8_ff, w8_in;
   logic [2:0][45:0] pm8_ff, pm8_in;
   logic [2:0]       pneg8_ff, pneg8_in;
   // stage 2
   vdd_pkg::scale_out_type w9_ff, w9_in;
   logic [2:0][45:0] x9_ff, x9_in;
   logic [2:0][30:0] g9_ff, g9_in;
   logic [2:0]       pneg9_ff, pneg9_in;
   // stage 3
   vdd_pkg::scale_out_type w10_ff, w10_in;
   logic [2:0][30:0] qest10_ff, qest10_in;
   logic [2:0][16:0] xlo10_ff, xlo10_in;
   logic [2:0][30:0] g10_ff, g10_in;
   logic [2:0]       pneg10_ff, pneg10_in;
   // stage 4
   logic [2:0][31:0] pos11_ff, pos11_in;
   logic [2:0][34:0] mag11_ff, mag11_in;
   logic [2:0]       neg11_ff, neg11_in;
   // stage 5
   logic [2:0][31:0] out12_ff, out12_in;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      shift_vld = {vld_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         vld_in[k] = adv[k] ? shift_vld[k] : vld_ff[k];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_pos   = out12_ff;

   // stage 1: scalar delta times matrix column entry or normal component
   always_comb begin
      logic [15:0] sel;
      logic [15:0] emag;
      w8_in = in_word;
      for (int i = 0; i < 3; i++) begin
         sel = cfg.mat[i][0];
         if (cfg.dir == vdd_pkg::DIR_Y) begin
            sel = cfg.mat[i][1];
         end
         if (cfg.dir == vdd_pkg::DIR_Z) begin
            sel = cfg.mat[i][2];
         end
         if (!(cfg.glob && cfg.dir <= vdd_pkg::DIR_Z)) begin
            sel = in_word.nrm[i];
         end
         emag        = sel[15] ? (~sel + 16'd1) : sel;
         pneg8_in[i] = in_word.dneg[0] ^ sel[15];
         pm8_in[i]   = 46'(in_word.dm[0][29:0]) * 46'(emag);
      end
   end

   // stage 2: Q2.14 rounding, bias for the rounded divide
   always_comb begin
      w9_in    = w8_ff;
      pneg9_in = pneg8_ff;
      for (int i = 0; i < 3; i++) begin
         g9_in[i] = 31'((pm8_ff[i] + 46'd8192) >> 14);
         x9_in[i] = pm8_ff[i] + 46'd16383;
      end
   end

   // stage 3: quotient estimate by 1/32767 = 2^-15 + 2^-30 + 2^-45 + ...
   always_comb begin
      w10_in    = w9_ff;
      pneg10_in = pneg9_ff;
      g10_in    = g9_ff;
      for (int i = 0; i < 3; i++) begin
         qest10_in[i] = 31'(x9_ff[i] >> 15) + 31'(x9_ff[i] >> 30) + 31'(x9_ff[i] >> 45);
         xlo10_in[i]  = x9_ff[i][16:0];
      end
   end

   // stage 4: correct the quotient (short by at most three), select displacement
   always_comb begin
      logic [16:0] rem;
      logic [30:0] q;
      pos11_in = w10_ff.pos;
      for (int i = 0; i < 3; i++) begin
         rem = xlo10_ff[i] - {qest10_ff[i][1:0], 15'd0} + qest10_ff[i][16:0];
         q   = qest10_ff[i] + 31'(rem >= 17'd32767) + 31'(rem >= 17'd65534)
             + 31'(rem >= 17'd98301);
         mag11_in[i] = '0;
         neg11_in[i] = 1'b0;
         if (!w10_ff.bypass) begin
            if (cfg.dir == vdd_pkg::DIR_RGB) begin
               mag11_in[i] = w10_ff.dm[i];
               neg11_in[i] = w10_ff.dneg[i];
            end else if (cfg.dir <= vdd_pkg::DIR_Z) begin
               if (cfg.glob) begin
                  mag11_in[i] = 35'(g10_ff[i]);
                  neg11_in[i] = pneg10_ff[i];
               end else if (cfg.dir == 3'(i)) begin
                  mag11_in[i] = w10_ff.dm[0];
                  neg11_in[i] = w10_ff.dneg[0];
               end
            end else begin
               mag11_in[i] = 35'(q);
               neg11_in[i] = pneg10_ff[i];
            end
         end
      end
   end

   // stage 5: add to position, saturate to 32 bits
   always_comb begin
      logic [36:0] sum;
      for (int i = 0; i < 3; i++) begin
         sum = neg11_ff[i]
             ? ({{5{pos11_ff[i][31]}}, pos11_ff[i]} - {2'b00, mag11_ff[i]})
             : ({{5{pos11_ff[i][31]}}, pos11_ff[i]} + {2'b00, mag11_ff[i]});
         if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
            out12_in[i] = sum[31:0];
         end else if (sum[36]) begin
            out12_in[i] = 32'h8000_0000;
         end else begin
            out12_in[i] = 32'h7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         w8_ff    <= w8_in;
         pm8_ff   <= pm8_in;
         pneg8_ff <= pneg8_in;
      end
      if (adv[1]) begin
         w9_ff    <= w9_in;
         x9_ff    <= x9_in;
         g9_ff    <= g9_in;
         pneg9_ff <= pneg9_in;
      end
      if (adv[2]) begin
         w10_ff    <= w10_in;
         qest10_ff <= qest10_in;
         xlo10_ff  <= xlo10_in;
         g10_ff    <= g10_in;
         pneg10_ff <= pneg10_in;
      end
      if (adv[3]) begin
         pos11_ff <= pos11_in;
         mag11_ff <= mag11_in;
         neg11_ff <= neg11_in;
      end
      if (adv[4]) begin
         out12_ff <= out12_in;
      end
   end

endmodule

// ===== sv/vertex_displace_deform_unit.sv =====
`timescale 1ns / 1ps
// Top level of the vertex displacement deformer: csr block and a 12-stage pipeline.
// Depends on vdd_pkg, vdd_csr, vdd_prep, vdd_scale and vdd_dir.
//
//   group   direction  word                     fields
//   req_    in         one vertex               position, texture, weight, normal
//   rsp_    out        one displaced vertex     out_x, out_y, out_z
//   csr_    in         register write           mode, strength, midlevel, mat_row0..2
//
// One vertex per cycle while rsp_ is not stalled. The pipeline has 12 register
// stages: operand prep (4), split strength multiply,
// clamp and round (3), direction multiply, divide by 32767 and final add (5).
// Each stage holds only while its successor is full, so empty stages keep
// filling behind a stalled rsp_ word. Reset clears every stage valid bit and
// loads the register defaults; there is no clearing pass.
module vertex_displace_deform_unit (
   input  logic                          clock,
   input  logic                          reset,
   // slave side
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, pos_z, tex_intensity, tex_red, tex_green, tex_blue, weight,
   // normal_x, normal_y, normal_z, 3 zero bits
   input  logic [vdd_pkg::ReqDataW-1:0]  req_tdata,
   // master side
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_x, out_y, out_z
   output logic [vdd_pkg::RspDataW-1:0]  rsp_tdata,
   // configuration
   input  logic                          csr_wen,
   input  logic [2:0]                    csr_index,
   input  logic [vdd_pkg::CsrDataW-1:0]  csr_wdata
);

   vdd_pkg::cfg_type       cfg;
   vdd_pkg::vertex_type    vtx;
   vdd_pkg::scale_in_type  prep_word;
   vdd_pkg::scale_out_type scale_word;
   logic                   prep_valid, prep_ready, scale_valid, scale_ready;
   logic [2:0][31:0]       out_pos;

   // unpack the req word
   always_comb begin
      vtx.pos[0]        = req_tdata[31:0];
      vtx.pos[1]        = req_tdata[63:32];
      vtx.pos[2]        = req_tdata[95:64];
      vtx.tex_intensity = req_tdata[112:96];
      vtx.rgb[0]        = req_tdata[129:113];
      vtx.rgb[1]        = req_tdata[146:130];
      vtx.rgb[2]        = req_tdata[163:147];
      vtx.weight        = req_tdata[180:164];
      vtx.nrm[0]        = req_tdata[196:181];
      vtx.nrm[1]        = req_tdata[212:197];
      vtx.nrm[2]        = req_tdata[228:213];
   end

   vdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vdd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vtx    (vtx),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_word  (prep_word)
   );

   vdd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_word   (prep_word),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_word  (scale_word)
   );

   vdd_dir u_dir (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (scale_valid),
      .in_ready  (scale_ready),
      .in_word   (scale_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pos   (out_pos)
   );

   // pack the rsp word
   assign rsp_tdata = {out_pos[2], out_pos[1], out_pos[0]};

endmodule

// ===== tb/vertex_displace_deform_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vertex_displace_deform_unit: streams vertices through req_/rsp_
// under several register settings and checks every displaced word against a local predictor.
// Depends on vdd_pkg and the RTL of the deformer only.
module vertex_displace_deform_unit_tb;

   // Mode register fields beyond the direction codes of the package
   localparam logic [5:0] MODE_GLOBAL  = 6'b001000;
   localparam logic [5:0] MODE_TEX     = 6'b010000;
   localparam logic [5:0] MODE_WEIGHTS = 6'b100000;
   localparam logic [2:0] DIR_SPARE6   = 3'd6;
   localparam logic [2:0] DIR_SPARE7   = 3'd7;
   // Register indexes that the block must ignore
   localparam logic [2:0] REG_UNUSED6  = 3'd6;
   localparam logic [2:0] REG_UNUSED7  = 3'd7;

   // Q32.32 magnitude limits of the strength products
   localparam longint DeltaLimit = 64'sd42949672960000;
   localparam longint RgbLimit   = 64'sd1125899906842624;

   localparam int PhaseItems    = 50;
   localparam int RandomPhases  = 14;
   localparam int LongHold      = 80;
   localparam int DrainCycles   = 20;
   localparam int WatchdogLimit = 2000;
   localparam int ReportCap     = 50;

   typedef struct packed {
      logic [2:0][15:0] nrm;
      logic [16:0]      weight;
      logic [2:0][16:0] rgb;
      logic [16:0]      inten;
      logic [2:0][31:0] pos;
   } vtx_type;

   typedef logic [2:0][31:0] xyz_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [vdd_pkg::ReqDataW-1:0]   req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [vdd_pkg::RspDataW-1:0]   rsp_tdata;
   logic                           csr_wen    = 1'b0;
   logic [2:0]                     csr_index  = '0;
   logic [vdd_pkg::CsrDataW-1:0]   csr_wdata  = '0;

   // Local copy of the register file
   logic [5:0]  cfg_mode     = vdd_pkg::ModeReset;
   logic [31:0] cfg_strength = vdd_pkg::StrengthReset;
   logic [31:0] cfg_midlevel = vdd_pkg::MidlevelReset;
   logic [47:0] cfg_row [3]  = '{vdd_pkg::Row0Reset, vdd_pkg::Row1Reset, vdd_pkg::Row2Reset};

   vtx_type   vertices_pending [$];
   xyz_type   positions_due [$];
   vtx_type   cur_vtx = '0;

   int     n_queued     = 0;
   int     n_accepted   = 0;
   int     n_checked    = 0;
   int     n_errors     = 0;
   int     n_settings   = 0;
   int     send_idle_pct = 20;
   int     recv_idle_pct = 20;
   int     hold_reqs    = 0;
   int     stall_cycles = 0;

   string  out_name [3] = '{"out_x", "out_y", "out_z"};

   vertex_displace_deform_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- arithmetic

   // Shift right with rounding to nearest, halves away from zero
   function automatic longint round_shift(longint x, int n);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + (64'sd1 <<< (n - 1))) >>> n;
      return (x < 0) ? -m : m;
   endfunction

   function automatic longint div_round_32767(longint x);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + 64'sd16383) / 64'sd32767;
      return (x < 0) ? -m : m;
   endfunction

   // Exact product, clamped to +-lim
   function automatic longint clamp_mul(longint a, longint b, longint lim);
      logic signed [127:0] wa, wb, p, wl;
      wa = 128'(a);
      wb = 128'(b);
      wl = 128'(lim);
      p  = wa * wb;
      if (p > wl)
         p = wl;
      else if (p < -wl)
         p = -wl;
      return p[63:0];
   endfunction

   function automatic logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647)
         x = 64'sd2147483647;
      if (x < -64'sd2147483648)
         x = -64'sd2147483648;
      return x[31:0];
   endfunction

   function automatic longint mat_coef(int r, int c);
      return longint'($signed(cfg_row[r][16*c +: 16]));
   endfunction

   // Displaced position of one vertex under the current register copy
   function automatic xyz_type displace(vtx_type v);
      logic [2:0] dir;
      logic       glob, tex, wen;
      longint     mid, s, w, t, delta, acc, r;
      longint     vec [3];
      longint     d [3];
      xyz_type    res;
      dir  = cfg_mode[2:0];
      glob = cfg_mode[3];
      tex  = cfg_mode[4];
      wen  = cfg_mode[5];
      mid  = longint'($signed(cfg_midlevel));
      s    = longint'($signed(cfg_strength));
      w    = longint'(v.weight);
      for (int i = 0; i < 3; i++)
         d[i] = 0;
      // zero weight with weights enabled, RGB without texture and spare codes leave the vertex alone
      if (!(wen && w == 0) && !(dir == vdd_pkg::DIR_RGB && !tex) && dir <= vdd_pkg::DIR_CUSTOM) begin
         if (wen)
            s = round_shift(s * w, 16);
         if (dir == vdd_pkg::DIR_RGB) begin
            for (int j = 0; j < 3; j++) begin
               vec[j] = longint'(v.rgb[j]);
               vec[j] = vec[j] - mid;
            end
            for (int i = 0; i < 3; i++) begin
               if (glob) begin
                  acc = 0;
                  for (int j = 0; j < 3; j++)
                     acc += mat_coef(i, j) * vec[j];
                  r = round_shift(acc, 14);
               end else begin
                  r = vec[i];
               end
               d[i] = round_shift(clamp_mul(r, s, RgbLimit), 16);
            end
         end else begin
            t = longint'(v.inten);
            t = tex ? t - mid : 64'sd65536 - mid;
            delta = round_shift(clamp_mul(t, s, DeltaLimit), 16);
            for (int i = 0; i < 3; i++) begin
               if (dir <= vdd_pkg::DIR_Z) begin
                  if (glob)
                     d[i] = round_shift(delta * mat_coef(i, int'(dir)), 14);
                  else
                     d[i] = (3'(i) == dir) ? delta : 0;
               end else begin
                  // normal and custom normal; global bit has no effect here
                  d[i] = div_round_32767(delta * longint'($signed(v.nrm[i])));
               end
            end
         end
      end
      for (int i = 0; i < 3; i++)
         res[i] = clamp32(longint'($signed(v.pos[i])) + d[i]);
      return res;
   endfunction

   // ---------------------------------------------------------------- random values

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [16:0] rand_unit();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(0, 17'h1FFFF));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [15:0] rand_nrm();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8001;
         2: return 16'h8000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 9))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'h0000;
         3: return 16'h7FFF;
         4: return 16'h8000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [47:0] rand_row();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic vtx_type rand_vertex();
      vtx_type v;
      for (int i = 0; i < 3; i++) begin
         v.pos[i] = rand_pos();
         v.rgb[i] = rand_unit();
         v.nrm[i] = rand_nrm();
      end
      v.inten  = rand_unit();
      v.weight = ($urandom_range(0, 7) == 0) ? 17'd0 : rand_unit();
      return v;
   endfunction

   // ---------------------------------------------------------------- sequencing

   task automatic queue_vertex(vtx_type v);
      vertices_pending.push_back(v);
      n_queued++;
   endtask

   // Wait until every queued vertex has come back
   task automatic settle();
      while (n_checked != n_queued)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         vdd_pkg::REG_MODE:     cfg_mode     = val[5:0];
         vdd_pkg::REG_STRENGTH: cfg_strength = val[31:0];
         vdd_pkg::REG_MIDLEVEL: cfg_midlevel = val[31:0];
         vdd_pkg::REG_ROW0:     cfg_row[0]   = val;
         vdd_pkg::REG_ROW1:     cfg_row[1]   = val;
         vdd_pkg::REG_ROW2:     cfg_row[2]   = val;
         default: ;
      endcase
   endtask

   task automatic load_config(logic [5:0] mode, logic [31:0] strength, logic [31:0] midlevel,
                              logic [47:0] r0, logic [47:0] r1, logic [47:0] r2);
      settle();
      write_reg(vdd_pkg::REG_MODE, {42'd0, mode});
      write_reg(vdd_pkg::REG_STRENGTH, {16'd0, strength});
      write_reg(vdd_pkg::REG_MIDLEVEL, {16'd0, midlevel});
      write_reg(vdd_pkg::REG_ROW0, r0);
      write_reg(vdd_pkg::REG_ROW1, r1);
      write_reg(vdd_pkg::REG_ROW2, r2);
      n_settings++;
   endtask

   // ---------------------------------------------------------------- request driver

   always @(negedge clock) begin : drive_req
      int   seen;
      int   gap;
      logic taken;
      logic nxt_valid;
      if (!reset) begin
         taken = (n_accepted != seen);
         seen  = n_accepted;
         if (taken && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 7);
         // hold the word until taken, then advance
         if (!req_tvalid || taken) begin
            if (gap > 0) begin
               gap--;
               nxt_valid = 1'b0;
            end else if (vertices_pending.size() != 0) begin
               cur_vtx   = vertices_pending.pop_front();
               nxt_valid = 1'b1;
            end else begin
               nxt_valid = 1'b0;
            end
            req_tvalid <= nxt_valid;
            req_tdata  <= {3'd0, cur_vtx.nrm, cur_vtx.weight, cur_vtx.rgb, cur_vtx.inten,
                           cur_vtx.pos};
         end
      end
   end

   // ---------------------------------------------------------------- response backpressure

   always @(negedge clock) begin : drive_rsp_ready
      int hold;
      int acks;
      if (!reset) begin
         if (acks != hold_reqs) begin
            acks = hold_reqs;
            hold = LongHold;
         end else if (hold == 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            hold = $urandom_range(1, 7);
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- monitor and watchdog

   always @(posedge clock) begin : monitor
      xyz_type want;
      logic    moved;
      if (!reset) begin
         moved = csr_wen;
         // predict on every accepted vertex word
         if (req_tvalid && req_tready) begin
            positions_due.push_back(displace(cur_vtx));
            n_accepted++;
            moved = 1'b1;
         end
         // compare each displaced word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (positions_due.size() == 0) begin
               if (n_errors < ReportCap)
                  $error("displaced word with no vertex outstanding: %h", rsp_tdata);
               n_errors++;
            end else begin
               want = positions_due.pop_front();
               n_checked++;
               for (int f = 0; f < 3; f++) begin
                  if (rsp_tdata[32*f +: 32] !== want[f]) begin
                     if (n_errors < ReportCap)
                        $error("%s expected %0d actual %0d", out_name[f], $signed(want[f]),
                               $signed(rsp_tdata[32*f +: 32]));
                     n_errors++;
                  end
               end
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("Timeout: no handshake for %0d cycles", WatchdogLimit);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      vtx_type     v;
      logic [5:0]  mode;
      logic [31:0] strength;
      logic [31:0] midlevel;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Defaults: normal direction, no texture; saturating positions and normals
      v = rand_vertex();
      v.pos = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      v.nrm = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      queue_vertex(v);
      v.pos = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      v.nrm = {16'h0000, 16'h8001, 16'h8000};
      queue_vertex(v);
      queue_vertex(rand_vertex());

      // Local X with texture: intensity at zero, one and beyond one
      load_config(MODE_TEX | {3'b000, vdd_pkg::DIR_X}, 32'h0001_0000, 32'h0000_8000,
                  vdd_pkg::Row0Reset, vdd_pkg::Row1Reset, vdd_pkg::Row2Reset);
      v = rand_vertex();
      v.inten = 17'd0;
      queue_vertex(v);
      v.inten = 17'd65536;
      queue_vertex(v);
      v.inten = 17'h1FFFF;
      queue_vertex(v);

      // Global Y, no texture
      load_config(MODE_GLOBAL | {3'b000, vdd_pkg::DIR_Y}, 32'h0002_0000, 32'hFFFF_0000,
                  rand_row(), rand_row(), rand_row());
      queue_vertex(rand_vertex());

      // Global Z with extreme strength and midlevel: delta clamps, extreme coefficients
      load_config(MODE_GLOBAL | MODE_TEX | {3'b000, vdd_pkg::DIR_Z}, 32'h7FFF_FFFF,
                  32'h8000_0000, 48'h7FFF_8000_4000, 48'h8000_7FFF_C000, 48'h0000_7FFF_8000);
      queue_vertex(rand_vertex());
      queue_vertex(rand_vertex());

      // Global RGB past the product limit
      load_config(MODE_GLOBAL | MODE_TEX | {3'b000, vdd_pkg::DIR_RGB}, 32'h7FFF_FFFF,
                  32'h8000_0000, 48'h7FFF_8000_4000, 48'h8000_7FFF_C000, 48'h0000_7FFF_8000);
      v = rand_vertex();
      v.rgb = {17'h1FFFF, 17'd0, 17'd65536};
      queue_vertex(v);
      queue_vertex(rand_vertex());

      // Local RGB, most negative strength
      load_config(MODE_TEX | {3'b000, vdd_pkg::DIR_RGB}, 32'h8000_0000, 32'h0000_0000,
                  vdd_pkg::Row0Reset, vdd_pkg::Row1Reset, vdd_pkg::Row2Reset);
      queue_vertex(rand_vertex());

      // RGB without texture passes the position through
      load_config({3'b000, vdd_pkg::DIR_RGB}, 32'h0001_0000, 32'h0000_8000,
                  vdd_pkg::Row0Reset, vdd_pkg::Row1Reset, vdd_pkg::Row2Reset);
      queue_vertex(rand_vertex());

      // Weights: zero weight, full weight, weight above one
      load_config(MODE_WEIGHTS | MODE_TEX | {3'b000, vdd_pkg::DIR_X}, 32'h7FFF_FFFF,
                  32'h0000_0000, vdd_pkg::Row0Reset, vdd_pkg::Row1Reset, vdd_pkg::Row2Reset);
      v = rand_vertex();
      v.weight = 17'd0;
      queue_vertex(v);
      v.weight = 17'd65536;
      queue_vertex(v);
      v.weight = 17'h1FFFF;
      queue_vertex(v);

      // Spare direction codes, the second with every mode bit set
      load_config({3'b000, DIR_SPARE6}, 32'h0001_0000, 32'h0000_8000,
                  rand_row(), rand_row(), rand_row());
      queue_vertex(rand_vertex());
      load_config({MODE_WEIGHTS[5:3] | MODE_TEX[5:3] | MODE_GLOBAL[5:3], DIR_SPARE7},
                  32'h0001_0000, 32'h0000_8000, rand_row(), rand_row(), rand_row());
      queue_vertex(rand_vertex());

      // Normal with the global bit, then custom normal with texture and weights
      load_config(MODE_GLOBAL | {3'b000, vdd_pkg::DIR_NORMAL}, 32'h8000_0000, 32'h7FFF_FFFF,
                  rand_row(), rand_row(), rand_row());
      queue_vertex(rand_vertex());
      load_config(MODE_WEIGHTS | MODE_TEX | {3'b000, vdd_pkg::DIR_CUSTOM}, 32'h0003_0000,
                  32'h0000_8000, rand_row(), rand_row(), rand_row());
      queue_vertex(rand_vertex());

      // Writes to unused indexes must not disturb the registers
      settle();
      write_reg(REG_UNUSED6, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_UNUSED7, 48'hFFFF_FFFF_FFFF);
      queue_vertex(rand_vertex());

      // All mode bits clear, zero strength
      load_config(6'd0, 32'h0000_0000, 32'h0000_0000, 48'd0, 48'd0, 48'd0);
      queue_vertex(rand_vertex());

      // Random phases, direction code stepping through all eight values
      for (int k = 0; k < RandomPhases; k++) begin
         mode     = {3'($urandom_range(0, 7)), 3'(k % 8)};
         strength = rand_q16();
         midlevel = ($urandom_range(0, 3) == 0) ? rand_q16() : $urandom_range(0, 65536);
         if (k == 1) begin
            strength = 32'h7FFF_FFFF;
            midlevel = 32'h8000_0000;
         end else if (k == 2) begin
            strength = 32'h8000_0000;
            midlevel = 32'h7FFF_FFFF;
         end
         load_config(mode, strength, midlevel, rand_row(), rand_row(), rand_row());
         if (k == RandomPhases - 1 || k % 3 == 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = 30;
            recv_idle_pct = 25;
         end
         // fill the pipeline against a long response stall
         if (k == 2) begin
            send_idle_pct = 0;
            hold_reqs++;
         end
         repeat (PhaseItems)
            queue_vertex(rand_vertex());
      end

      settle();
      repeat (DrainCycles) @(negedge clock);
      $display("Checked %0d of %0d vertices over %0d register settings", n_checked, n_queued,
               n_settings);
      $display("Covered all direction codes, global, texture, weights and a long output stall");
      if (n_errors == 0 && positions_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
sv/vdd_pkg.sv
sv/vdd_csr.sv
sv/vdd_prep.sv
sv/vdd_scale.sv
sv/vdd_dir.sv
sv/vertex_displace_deform_unit.sv
tb/vertex_displace_deform_unit_tb.sv
